FILE: rtl/demand_paging_lru_translator_assert.svh
// assertion macros shared by the translator checker
`ifndef DEMAND_PAGING_LRU_TRANSLATOR_ASSERT_SVH
`define DEMAND_PAGING_LRU_TRANSLATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DPLT_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("translator check failed");

// next-cycle implication, checked out of reset
`define DPLT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("translator check failed");

`endif

FILE: rtl/dplt_pkg.sv
// shared constants and controller/datapath interface types for the translator
`timescale 1ns / 1ps

package dplt_pkg;

    localparam int DEF_PAGES   = 256;
    localparam int DEF_FRAMES  = 64;
    localparam int ADDR_W      = 24;
    localparam int OB_W        = 5;
    localparam int OFFSET_W    = 16;
    localparam int FRAME_OUT_W = 6;
    localparam int CNT_W       = 32;

    localparam logic [OB_W-1:0] OB_RESET = 5'd8;
    localparam logic [OB_W-1:0] OB_MAX   = 5'd16;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic finish_oor;
        logic finish_hit;
        logic take_free;
        logic scan_step;
        logic evict_clear;
        logic map_finish;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic oor;
        logic hit;
        logic full;
        logic scan_done;
    } status_t;

endpackage

FILE: rtl/dplt_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module dplt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/dplt_ctrl.sv
// sequencing state machine for the translator
`timescale 1ns / 1ps

module dplt_ctrl
    import dplt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_LOOKUP = 8'b0000_0100,
        ST_DECIDE = 8'b0000_1000,
        ST_SCAN   = 8'b0001_0000,
        ST_EV_RD  = 8'b0010_0000,
        ST_EV_WR  = 8'b0100_0000,
        ST_MAP    = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                priority if (status.oor)
                begin
                    cmd.finish_oor = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (status.hit)
                begin
                    cmd.finish_hit = 1'b1;
                    state_next     = ST_IDLE;
                end
                else if (!status.full)
                begin
                    cmd.take_free = 1'b1;
                    state_next    = ST_MAP;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_EV_RD;
                end
            end
            ST_EV_RD:
            begin
                state_next = ST_EV_WR;
            end
            ST_EV_WR:
            begin
                cmd.evict_clear = 1'b1;
                state_next      = ST_MAP;
            end
            ST_MAP:
            begin
                cmd.map_finish = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: rtl/dplt_datapath.sv
// page table, frame tables, counters and result registers
`timescale 1ns / 1ps

module dplt_datapath
    import dplt_pkg::*;
#(
    parameter int PAGES  = DEF_PAGES,
    parameter int FRAMES = DEF_FRAMES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic [ADDR_W-1:0]      virtual_address,
    input  logic                   cfg_valid,
    input  logic [OB_W-1:0]        cfg_data,
    output logic                   done,
    output logic [FRAME_OUT_W-1:0] frame_number,
    output logic [OFFSET_W-1:0]    page_offset,
    output logic                   was_hit,
    output logic                   out_of_range,
    output logic [CNT_W-1:0]       hit_total,
    output logic [CNT_W-1:0]       miss_total
);

    localparam int PW = $clog2(PAGES);
    localparam int FW = $clog2(FRAMES);

    // configuration
    logic [OB_W-1:0] offset_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OB_RESET;
        end
        else if (cfg_valid)
        begin
            offset_bits_reg <= cfg_data;
        end
    end

    // address split
    logic [OB_W-1:0]     ob_eff;
    logic [ADDR_W-1:0]   page_full;
    logic [ADDR_W-1:0]   offset_mask;
    logic [PW-1:0]       page_reg;
    logic                oor_reg;
    logic [OFFSET_W-1:0] offset_reg;

    always_comb
    begin
        ob_eff      = (offset_bits_reg > OB_MAX) ? OB_MAX : offset_bits_reg;
        page_full   = virtual_address >> ob_eff;
        offset_mask = ~({ADDR_W{1'b1}} << ob_eff);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg   <= PW'(page_full);
            oor_reg    <= (page_full >= ADDR_W'(PAGES));
            offset_reg <= OFFSET_W'(virtual_address & offset_mask);
        end
    end

    // control counters
    logic [PW-1:0]    clr_cnt_reg;
    logic [FW:0]      next_free_reg;
    logic [FW:0]      scan_cnt_reg;
    logic [CNT_W-1:0] stamp_reg;
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] stamp_next;

    assign stamp_next = stamp_reg + CNT_W'(1);

    // memories
    logic [FW:0]      pt_wdata;
    logic [PW-1:0]    pt_waddr;
    logic             pt_we;
    logic [FW:0]      pt_rdata;
    logic [FW-1:0]    lu_waddr;
    logic             lu_we;
    logic [CNT_W-1:0] lu_rdata;
    logic [PW-1:0]    fp_rdata;
    logic [FW-1:0]    victim_reg;
    logic [CNT_W-1:0] best_val_reg;
    logic             better;

    always_comb
    begin
        pt_we    = cmd.clear_step | cmd.evict_clear | cmd.map_finish;
        pt_waddr = page_reg;
        pt_wdata = {1'b1, victim_reg};
        priority if (cmd.clear_step)
        begin
            pt_waddr = clr_cnt_reg;
            pt_wdata = '0;
        end
        else if (cmd.evict_clear)
        begin
            pt_waddr = fp_rdata;
            pt_wdata = '0;
        end
        else
        begin
            pt_waddr = page_reg;
            pt_wdata = {1'b1, victim_reg};
        end
    end

    dplt_ram #(
        .WIDTH (FW + 1),
        .DEPTH (PAGES)
    ) u_page_table (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (page_reg),
        .rdata (pt_rdata)
    );

    assign lu_we    = cmd.finish_hit | cmd.map_finish;
    assign lu_waddr = cmd.finish_hit ? pt_rdata[FW-1:0] : victim_reg;

    dplt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (FRAMES)
    ) u_last_use (
        .clk   (clk),
        .we    (lu_we),
        .waddr (lu_waddr),
        .wdata (stamp_next),
        .raddr (scan_cnt_reg[FW-1:0]),
        .rdata (lu_rdata)
    );

    // owning page of each frame, for eviction
    dplt_ram #(
        .WIDTH (PW),
        .DEPTH (FRAMES)
    ) u_frame_page (
        .clk   (clk),
        .we    (cmd.map_finish),
        .waddr (victim_reg),
        .wdata (page_reg),
        .raddr (victim_reg),
        .rdata (fp_rdata)
    );

    assign better = (scan_cnt_reg == (FW+1)'(1)) || (lu_rdata < best_val_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.take_free)
        begin
            victim_reg <= next_free_reg[FW-1:0];
        end
        else if (cmd.scan_step && (scan_cnt_reg != '0) && better)
        begin
            victim_reg   <= FW'(scan_cnt_reg - (FW+1)'(1));
            best_val_reg <= lu_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            next_free_reg <= '0;
            scan_cnt_reg  <= '0;
            stamp_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + PW'(1);
            end
            if (cmd.load)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_cnt_reg <= scan_cnt_reg + (FW+1)'(1);
            end
            if (cmd.take_free)
            begin
                next_free_reg <= next_free_reg + (FW+1)'(1);
            end
            if (cmd.finish_hit)
            begin
                stamp_reg   <= stamp_next;
                hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
            end
            if (cmd.map_finish)
            begin
                stamp_reg    <= stamp_next;
                miss_cnt_reg <= miss_cnt_reg + CNT_W'(1);
            end
        end
    end

    // result
    logic                   done_reg;
    logic [FRAME_OUT_W-1:0] frame_out_reg;
    logic                   was_hit_reg;
    logic                   oor_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish_oor | cmd.finish_hit | cmd.map_finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish_oor)
        begin
            frame_out_reg <= '0;
            was_hit_reg   <= 1'b0;
            oor_out_reg   <= 1'b1;
        end
        else if (cmd.finish_hit)
        begin
            frame_out_reg <= FRAME_OUT_W'(pt_rdata[FW-1:0]);
            was_hit_reg   <= 1'b1;
            oor_out_reg   <= 1'b0;
        end
        else if (cmd.map_finish)
        begin
            frame_out_reg <= FRAME_OUT_W'(victim_reg);
            was_hit_reg   <= 1'b0;
            oor_out_reg   <= 1'b0;
        end
    end

    assign status.clear_done = (clr_cnt_reg == PW'(PAGES - 1));
    assign status.oor        = oor_reg;
    assign status.hit        = pt_rdata[FW];
    assign status.full       = (next_free_reg == (FW+1)'(FRAMES));
    assign status.scan_done  = (scan_cnt_reg == (FW+1)'(FRAMES));

    assign done         = done_reg;
    assign frame_number = frame_out_reg;
    assign page_offset  = offset_reg;
    assign was_hit      = was_hit_reg;
    assign out_of_range = oor_out_reg;
    assign hit_total    = hit_cnt_reg;
    assign miss_total   = miss_cnt_reg;

endmodule

FILE: rtl/demand_paging_lru_translator.sv
// demand-paging address translator with lru frame replacement, top level
// a hit or out-of-range page finishes after the page table lookup; a miss takes the next free frame,
// or with all frames in use scans for the lru frame (one frame last-use word read per cycle) and evicts it
// one item at a time: busy stays high until the result strobe, next start taken in that cycle
// after reset busy stays high while the page table is swept to invalid
// results are shown for one cycle on done; the receiver cannot stall
`timescale 1ns / 1ps

module demand_paging_lru_translator
    import dplt_pkg::*;
#(
    parameter int PAGES  = DEF_PAGES,
    parameter int FRAMES = DEF_FRAMES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // item in
    input  logic                   start,
    output logic                   busy,
    input  logic [ADDR_W-1:0]      virtual_address,
    // offset width register
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [OB_W-1:0]        cfg_data,
    // result out
    output logic                   done,
    output logic [FRAME_OUT_W-1:0] frame_number,
    output logic [OFFSET_W-1:0]    page_offset,
    output logic                   was_hit,
    output logic                   out_of_range,
    output logic [CNT_W-1:0]       hit_total,
    output logic [CNT_W-1:0]       miss_total
);

    cmd_t    cmd;
    status_t status;

    // register writes are always taken; the user must write only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    // controller: clearing pass, lookup, free-frame take or lru scan, eviction, mapping
    dplt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // datapath: page table ram, last-use and owner-page rams, fill count,
    // access stamp, hit/miss counters and result registers
    dplt_datapath #(
        .PAGES  (PAGES),
        .FRAMES (FRAMES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .virtual_address (virtual_address),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .done            (done),
        .frame_number    (frame_number),
        .page_offset     (page_offset),
        .was_hit         (was_hit),
        .out_of_range    (out_of_range),
        .hit_total       (hit_total),
        .miss_total      (miss_total)
    );

endmodule

FILE: rtl/dplt_checker.sv
// port-level checks on the translator, bound to the top level
`timescale 1ns / 1ps

`include "demand_paging_lru_translator_assert.svh"

module dplt_checker
    import dplt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input logic                   was_hit,
    input logic                   out_of_range,
    input logic [FRAME_OUT_W-1:0] frame_number
);

    `DPLT_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy)
    `DPLT_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `DPLT_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy && !done)
    `DPLT_ASSERT_NOW(a_oor_result, clk, rst_n, done && out_of_range, !was_hit && frame_number == '0)

endmodule

bind demand_paging_lru_translator dplt_checker u_checker (.*);

FILE: sim/tb_demand_paging_lru_translator.sv
// self-checking testbench for the demand-paging lru translator
`timescale 1ns / 1ps

module tb_demand_paging_lru_translator;
    import dplt_pkg::*;

    localparam int PAGES  = DEF_PAGES;
    localparam int FRAMES = DEF_FRAMES;
    // run limit in ns, several times the slowest legal run
    localparam int RUN_LIMIT_NS = 2_000_000;
    // items per random phase
    localparam int PHASE_ITEMS = 88;

    // one translation as it leaves the block
    typedef struct packed {
        logic [FRAME_OUT_W-1:0] frame;
        logic [OFFSET_W-1:0]    offset;
        logic                   hit;
        logic                   oor;
        logic [CNT_W-1:0]       hits;
        logic [CNT_W-1:0]       misses;
    } xlat_t;

    typedef enum logic {ROW_XLAT, ROW_CFG} row_kind_t;

    // one row of the directed table: an address, or a new offset width
    typedef struct packed {
        row_kind_t         kind;
        logic              typed;
        logic [ADDR_W-1:0] value;
        xlat_t             want;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [ADDR_W-1:0] virtual_address = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [OB_W-1:0] cfg_data = '0;
    logic done;
    logic [FRAME_OUT_W-1:0] frame_number;
    logic [OFFSET_W-1:0] page_offset;
    logic was_hit;
    logic out_of_range;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;

    // shadow copy of the translator state
    logic [OB_W-1:0]  offset_width;
    logic             pt_valid [PAGES];
    logic [5:0]       pt_frame [PAGES];
    logic             frame_taken [FRAMES];
    logic [31:0]      frame_stamp [FRAMES];
    logic [31:0]      access_clock;
    logic [CNT_W-1:0] hit_cnt;
    logic [CNT_W-1:0] miss_cnt;

    xlat_t     expected_xlats[$];
    step_row_t directed_rows[$];

    int mismatches = 0;
    int n_hit = 0;
    int n_miss = 0;
    int n_evict = 0;
    int n_oor = 0;
    int n_widths = 0;
    bit steady = 1'b0;
    int unsigned hot_base = 0;

    always #2 clk = ~clk;

    demand_paging_lru_translator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .virtual_address (virtual_address),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .done            (done),
        .frame_number    (frame_number),
        .page_offset     (page_offset),
        .was_hit         (was_hit),
        .out_of_range    (out_of_range),
        .hit_total       (hit_total),
        .miss_total      (miss_total)
    );

    // shadow state back to its reset values
    function automatic void clear_shadow();
        offset_width = OB_RESET;
        for (int p = 0; p < PAGES; p++)
        begin
            pt_valid[p] = 1'b0;
            pt_frame[p] = '0;
        end
        for (int f = 0; f < FRAMES; f++)
        begin
            frame_taken[f] = 1'b0;
            frame_stamp[f] = '0;
        end
        access_clock = '0;
        hit_cnt = '0;
        miss_cnt = '0;
    endfunction

    // translate one address and advance the shadow state
    function automatic xlat_t translate_page(input logic [ADDR_W-1:0] addr);
        xlat_t r;
        int unsigned ob;
        int unsigned page;
        int unsigned victim;
        bit found;
        ob = (offset_width > OB_MAX) ? OB_MAX : offset_width;
        page = addr >> ob;
        r = '0;
        r.offset = OFFSET_W'(addr & ((32'd1 << ob) - 1));
        if (page >= PAGES)
        begin
            r.oor = 1'b1;
            n_oor++;
        end
        else
        begin
            if (pt_valid[page])
            begin
                r.frame = pt_frame[page];
                r.hit = 1'b1;
                hit_cnt++;
                n_hit++;
            end
            else
            begin
                // lowest never-used frame first
                found = 1'b0;
                victim = 0;
                for (int f = 0; f < FRAMES && !found; f++)
                begin
                    if (!frame_taken[f])
                    begin
                        frame_taken[f] = 1'b1;
                        victim = f;
                        found = 1'b1;
                    end
                end
                // all in use: oldest stamp, ties to the lowest frame
                if (!found)
                begin
                    n_evict++;
                    for (int f = 1; f < FRAMES; f++)
                        if (frame_stamp[f] < frame_stamp[victim])
                            victim = f;
                    for (int p = 0; p < PAGES && !found; p++)
                    begin
                        if (pt_valid[p] && pt_frame[p] == victim)
                        begin
                            pt_valid[p] = 1'b0;
                            found = 1'b1;
                        end
                    end
                end
                pt_frame[page] = FRAME_OUT_W'(victim);
                pt_valid[page] = 1'b1;
                r.frame = FRAME_OUT_W'(victim);
                miss_cnt++;
                n_miss++;
            end
            access_clock++;
            frame_stamp[r.frame] = access_clock;
        end
        r.hits = hit_cnt;
        r.misses = miss_cnt;
        return r;
    endfunction

    // random address shaped to stay mostly inside the page table
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned ob;
        int unsigned roll;
        int unsigned page;
        logic [31:0] a;
        ob = (offset_width > OB_MAX) ? OB_MAX : offset_width;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return ADDR_W'($urandom);
        if (roll < 12)
            page = PAGES + $urandom_range(0, 3);
        else if (roll < 55)
            page = hot_base + $urandom_range(0, 7);
        else
            page = $urandom_range(0, PAGES - 1);
        a = (page << ob) | ($urandom & ((32'd1 << ob) - 1));
        return a[ADDR_W-1:0];
    endfunction

    function automatic step_row_t xlat_row(input logic [ADDR_W-1:0] addr);
        step_row_t r;
        r = '0;
        r.kind = ROW_XLAT;
        r.value = addr;
        return r;
    endfunction

    function automatic step_row_t xlat_known(input logic [ADDR_W-1:0] addr,
                                             input logic [FRAME_OUT_W-1:0] frame,
                                             input logic [OFFSET_W-1:0] offset,
                                             input logic hit, input logic oor,
                                             input logic [CNT_W-1:0] hits,
                                             input logic [CNT_W-1:0] misses);
        step_row_t r;
        r = xlat_row(addr);
        r.typed = 1'b1;
        r.want = '{frame, offset, hit, oor, hits, misses};
        return r;
    endfunction

    function automatic step_row_t cfg_row(input logic [OB_W-1:0] width);
        step_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.value = ADDR_W'(width);
        return r;
    endfunction

    // present one address, hold it until taken, then log its translation
    task automatic issue(input logic [ADDR_W-1:0] addr, input logic typed,
                         input xlat_t want);
        logic taken;
        xlat_t predicted;
        while (!steady && $urandom_range(0, 99) < 9)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        virtual_address <= addr;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        predicted = translate_page(addr);
        expected_xlats.push_back(typed ? want : predicted);
    endtask

    // stop issuing and let every outstanding translation come back
    task automatic drain();
        start <= 1'b0;
        while (expected_xlats.size() != 0)
            @(posedge clk);
    endtask

    // offset width write, only while the block is idle
    task automatic write_offset_width(input logic [OB_W-1:0] width);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_data <= width;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        offset_width = width;
        n_widths++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // results are marked by done for one cycle; sample mid-cycle, well clear of the edge
    always @(negedge clk)
    begin
        xlat_t want;
        if (rst_n && done)
        begin
            if (expected_xlats.size() == 0)
            begin
                $error("result with no item outstanding: frame 0x%0h offset 0x%0h",
                       frame_number, page_offset);
                mismatches++;
            end
            else
            begin
                want = expected_xlats.pop_front();
                check_field("frame_number", 32'(want.frame), 32'(frame_number));
                check_field("page_offset", 32'(want.offset), 32'(page_offset));
                check_field("was_hit", 32'(want.hit), 32'(was_hit));
                check_field("out_of_range", 32'(want.oor), 32'(out_of_range));
                check_field("hit_total", want.hits, hit_total);
                check_field("miss_total", want.misses, miss_total);
            end
        end
    end

    // hard stop in case the block hangs
    initial
    begin
        #RUN_LIMIT_NS;
        $display("timeout with %0d translations outstanding", expected_xlats.size());
        $display("tb_demand_paging_lru_translator: FAIL");
        $finish;
    end

    initial
    begin
        logic [OB_W-1:0] phase_width [6];
        int settle;
        clear_shadow();

        // directed part, starting from the reset offset width of 8
        // first touch of page 0 misses into frame 0, then hits
        directed_rows.push_back(xlat_known(24'h000000, 6'd0, 16'h0000, 1'b0, 1'b0, 0, 1));
        directed_rows.push_back(xlat_known(24'h0000FF, 6'd0, 16'h00FF, 1'b1, 1'b0, 1, 1));
        // top address is far beyond the table: flagged, counts unchanged
        directed_rows.push_back(xlat_known(24'hFFFFFF, 6'd0, 16'h00FF, 1'b0, 1'b1, 1, 1));
        // last page in the table, next free frame
        directed_rows.push_back(xlat_known(24'h00FF00, 6'd1, 16'h0000, 1'b0, 1'b0, 1, 2));
        // first page past the table
        directed_rows.push_back(xlat_known(24'h010000, 6'd0, 16'h0000, 1'b0, 1'b1, 1, 2));
        // no offset at all: the address is the page
        directed_rows.push_back(cfg_row(5'd0));
        directed_rows.push_back(xlat_known(24'h0000FF, 6'd1, 16'h0000, 1'b1, 1'b0, 2, 2));
        directed_rows.push_back(xlat_known(24'h000100, 6'd0, 16'h0000, 1'b0, 1'b1, 2, 2));
        directed_rows.push_back(xlat_row(24'h000000));
        // widest offset
        directed_rows.push_back(cfg_row(5'd16));
        directed_rows.push_back(xlat_known(24'hFFFFFF, 6'd1, 16'hFFFF, 1'b1, 1'b0, 4, 2));
        directed_rows.push_back(xlat_row(24'h00ABCD));
        directed_rows.push_back(xlat_row(24'h5A0000));
        // widths above sixteen behave as sixteen
        directed_rows.push_back(cfg_row(5'd31));
        directed_rows.push_back(xlat_row(24'h7F1234));
        directed_rows.push_back(xlat_row(24'h5AFFFF));
        directed_rows.push_back(cfg_row(5'd17));
        directed_rows.push_back(xlat_row(24'h808001));
        directed_rows.push_back(cfg_row(5'd10));
        directed_rows.push_back(xlat_row(24'h03FFFF));
        directed_rows.push_back(xlat_row(24'h040000));
        directed_rows.push_back(xlat_row(24'hAAAAAA));
        directed_rows.push_back(xlat_row(24'h555555));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the block sweeps its page table after reset; issue() waits on busy
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain();
                write_offset_width(directed_rows[i].value[OB_W-1:0]);
            end
            else
                issue(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases, each at its own offset width; the third runs with no gaps
        phase_width = '{5'd12, 5'd0, 5'd16, 5'd4, 5'd20, 5'd8};
        phase_width[5] = OB_W'($urandom_range(0, 31));
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            write_offset_width(phase_width[ph]);
            steady = (ph == 2);
            hot_base = $urandom_range(0, PAGES - 8);
            repeat (PHASE_ITEMS)
                issue(pick_address(), 1'b0, '0);
        end
        steady = 1'b0;

        // wind down: bounded wait for stragglers, then watch for stray results
        start <= 1'b0;
        settle = 0;
        while (expected_xlats.size() != 0 && settle < 4 * FRAMES + 64)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (FRAMES + 8) @(posedge clk);
        if (expected_xlats.size() != 0)
        begin
            $error("%0d translations never came back", expected_xlats.size());
            mismatches++;
        end

        $display("covered %0d hits, %0d misses (%0d with eviction), %0d out-of-range pages",
                 n_hit, n_miss, n_evict, n_oor);
        $display("across %0d offset width writes, %0d mismatches", n_widths, mismatches);
        if (mismatches == 0)
            $display("tb_demand_paging_lru_translator: PASS");
        else
            $display("tb_demand_paging_lru_translator: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/dplt_pkg.sv
rtl/dplt_ram.sv
rtl/dplt_ctrl.sv
rtl/dplt_datapath.sv
rtl/demand_paging_lru_translator.sv
rtl/dplt_checker.sv
sim/tb_demand_paging_lru_translator.sv
